// ===== hw/rtl/open_addressing_hash_table_macros.svh =====
// Assertion macros for the open-addressing hash table checker.
// Needs signals named clk and rst_n in the scope of use.
`ifndef OPEN_ADDRESSING_HASH_TABLE_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define OAHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oaht assertion failed");

// Next-cycle implication, disabled during reset
`define OAHT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oaht assertion failed");

`endif

// ===== hw/rtl/oaht_pkg.sv =====
// Shared types and codes for the open-addressing hash table.
// No dependencies; used by controller, datapath, top level and checker.
package oaht_pkg;

  localparam int KEY_W  = 64;
  localparam int VAL_W  = 64;
  localparam int CAPW   = 5;   // internal width of log2 capacity
  localparam int CAPO_W = 4;   // capacity field width on the result
  localparam int COLL_W = 32;
  localparam int IN_W   = 192;
  localparam logic [CAPW-1:0] RST_CAP = CAPW'(4);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FOUND    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } st_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PRD,
    S_PCHK,
    S_GRD,
    S_GCHK,
    S_RRD,
    S_RLD,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic cfg_load;
    logic clr_step;
    logic item_load;
    logic probe_adv;
    logic count_coll;
    logic place;
    logic upd_val;
    logic res_we;
    st_t  res_st;
    logic res_val;
    logic grow_start;
    logic grow_step;
    logic grow_finish;
    logic re_load;
    logic re_next;
    logic item_reprobe;
    logic addr_scan;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic clr_done;
    logic used;
    logic match;
    logic lim;
    logic first;
    logic need_grow;
    logic at_max;
    logic grow_last;
    logic re_last;
    logic re_empty;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/oaht_ctrl.sv =====
// Controller state machine of the hash table: probe, growth and reinsertion.
// Depends on oaht_pkg; drives oaht_dp through cmd_t, reads sts_t.
module oaht_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [1:0]     in_tuser,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  oaht_pkg::sts_t sts,
  output oaht_pkg::cmd_t cmd
);
  import oaht_pkg::*;

  state_t state_r, state_nxt;
  logic   rehash_r, rehash_nxt;  // probing an old entry during growth
  logic   again_r, again_nxt;    // second probe of an insert after growth

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      rehash_r <= 1'b0;
      again_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rehash_r <= rehash_nxt;
      again_r  <= again_nxt;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    cmd.res_st = ST_OK;
    state_nxt  = state_r;
    rehash_nxt = rehash_r;
    again_nxt  = again_r;
    in_tready  = 1'b0;
    cfg_ready  = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.item_load = 1'b1;
          rehash_nxt    = 1'b0;
          again_nxt     = 1'b0;
          state_nxt     = (op_t'(in_tuser) == OP_NONE) ? S_DONE : S_PRD;
        end
      end
      S_PRD: state_nxt = S_PCHK;
      S_PCHK: begin
        // collision at the home slot
        if (sts.used && !sts.match && sts.first) cmd.count_coll = 1'b1;
        if (!sts.used || sts.match || sts.lim) begin
          if (rehash_r) begin
            cmd.place   = 1'b1;
            cmd.re_next = 1'b1;
            if (sts.re_last) begin
              cmd.item_reprobe = 1'b1;
              rehash_nxt       = 1'b0;
              again_nxt        = 1'b1;
              state_nxt        = S_PRD;
            end else begin
              state_nxt = S_RRD;
            end
          end else begin
            state_nxt = S_DONE;
            unique case (sts.op)
              OP_LOOKUP: begin
                cmd.res_we  = 1'b1;
                cmd.res_st  = sts.match ? ST_FOUND : ST_NOTFOUND;
                cmd.res_val = sts.match;
              end
              OP_UPDATE: begin
                cmd.res_we  = 1'b1;
                cmd.res_st  = sts.match ? ST_OK : ST_NOTFOUND;
                cmd.upd_val = sts.match;
              end
              OP_INSERT: begin
                cmd.res_we = 1'b1;
                priority if (again_r) begin
                  cmd.place  = 1'b1;
                  cmd.res_st = ST_OK;
                end else if (sts.match) begin
                  cmd.res_st = ST_FOUND;
                end else if (sts.need_grow && sts.at_max) begin
                  cmd.res_st = ST_FULL;
                end else if (sts.need_grow) begin
                  cmd.res_we     = 1'b0;
                  cmd.grow_start = 1'b1;
                  state_nxt      = S_GRD;
                end else begin
                  cmd.place  = 1'b1;
                  cmd.res_st = ST_OK;
                end
              end
              default: ;
            endcase
          end
        end else begin
          cmd.probe_adv = 1'b1;
          state_nxt     = S_PRD;
        end
      end
      S_GRD: begin
        cmd.addr_scan = 1'b1;
        state_nxt     = S_GCHK;
      end
      S_GCHK: begin
        cmd.addr_scan = 1'b1;
        cmd.grow_step = 1'b1;
        if (sts.grow_last) begin
          cmd.grow_finish = 1'b1;
          state_nxt       = S_RRD;
        end else begin
          state_nxt = S_GRD;
        end
      end
      S_RRD: begin
        if (sts.re_empty) begin
          cmd.item_reprobe = 1'b1;
          again_nxt        = 1'b1;
          state_nxt        = S_PRD;
        end else begin
          state_nxt = S_RLD;
        end
      end
      S_RLD: begin
        cmd.re_load = 1'b1;
        rehash_nxt  = 1'b1;
        state_nxt   = S_PRD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
    // a configuration write restarts the table
    if (cfg_valid) begin
      cmd          = '0;
      cmd.res_st   = ST_OK;
      cmd.cfg_load = 1'b1;
      in_tready    = 1'b0;
      state_nxt    = S_CLEAR;
    end
  end

endmodule

// ===== hw/rtl/oaht_dp.sv =====
// Datapath of the hash table: slot memories, probe index unit, scratch store,
// counters and the result register. Depends on oaht_pkg; driven by oaht_ctrl.
module oaht_dp #(
  parameter int MAX_CAPACITY_LOG2 = 10,
  parameter int OUT_W             = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [oaht_pkg::IN_W-1:0]     in_tdata,
  input  logic [1:0]                    in_tuser,
  input  logic [3:0]                    cfg_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_W-1:0]              out_tdata,
  output logic [1:0]                    out_tuser,
  input  oaht_pkg::cmd_t                cmd,
  output oaht_pkg::sts_t                sts
);
  import oaht_pkg::*;

  localparam int SW    = MAX_CAPACITY_LOG2;
  localparam int DEPTH = 1 << SW;
  localparam int CW    = SW + 1;
  localparam int AW    = SW + 5;

  // input unpack
  logic [KEY_W-1:0] in_key, in_hash;
  logic [VAL_W-1:0] in_val;
  assign in_key  = in_tdata[63:0];
  assign in_hash = in_tdata[127:64];
  assign in_val  = in_tdata[191:128];

  // memories
  logic                   used_mem [DEPTH];
  logic [KEY_W-1:0]       key_mem  [DEPTH];
  logic [KEY_W-1:0]       hash_mem [DEPTH];
  logic [VAL_W-1:0]       val_mem  [DEPTH];
  logic [3*KEY_W-1:0]     scr_mem  [DEPTH];

  logic                   used_q;
  logic [KEY_W-1:0]       key_q, hash_q;
  logic [VAL_W-1:0]       val_q;
  logic [3*KEY_W-1:0]     scr_q;

  // registers
  op_t              op_r;
  logic [KEY_W-1:0] ikey_r, ihash_r, ckey_r, chash_r, pert_r;
  logic [VAL_W-1:0] ival_r, cval_r, res_val_r;
  logic [SW-1:0]    idx_r;
  logic [AW-1:0]    adv_r;
  logic [CAPW-1:0]  cap_r;
  logic [CW-1:0]    cnt_r;
  logic [COLL_W-1:0] coll_r;
  logic [SW:0]      scan_r, nent_r;
  st_t              res_st_r, out_st_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic [SW:0]      cap_size;
  logic [SW-1:0]    mask, idx5, idx_nxt, rd_addr;
  logic [KEY_W-1:0] pert_nxt;
  logic [CAPW-1:0]  cfg_cap;

  assign cap_size = (SW+1)'(1) << cap_r;
  assign mask     = SW'(cap_size - 1'b1);
  assign cfg_cap  = ({1'b0, cfg_data} > CAPW'(SW)) ? CAPW'(SW) : {1'b0, cfg_data};

  // perturbation probe step
  assign pert_nxt = pert_r >> 5;
  assign idx5     = {idx_r[SW-3 >= 0 ? SW-3 : 0:0], 2'b00} + idx_r;
  assign idx_nxt  = (idx5 + pert_nxt[SW-1:0] + SW'(1)) & mask;

  assign rd_addr = cmd.addr_scan ? scan_r[SW-1:0] : idx_r;

  // memory read and write ports
  always_ff @(posedge clk) begin
    used_q <= used_mem[rd_addr];
    key_q  <= key_mem[rd_addr];
    hash_q <= hash_mem[rd_addr];
    val_q  <= val_mem[rd_addr];
    scr_q  <= scr_mem[scan_r[SW-1:0]];
    if (cmd.place) begin
      used_mem[idx_r] <= 1'b1;
    end else if (cmd.clr_step || cmd.grow_step) begin
      used_mem[scan_r[SW-1:0]] <= 1'b0;
    end
    if (cmd.place) begin
      key_mem[idx_r]  <= ckey_r;
      hash_mem[idx_r] <= chash_r;
    end
    if (cmd.place || cmd.upd_val) val_mem[idx_r] <= cval_r;
    if (cmd.grow_step && used_q) scr_mem[nent_r[SW-1:0]] <= {val_q, hash_q, key_q};
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= (RST_CAP > CAPW'(SW)) ? CAPW'(SW) : RST_CAP;
      cnt_r       <= '0;
      coll_r      <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cfg_load) begin
        cap_r  <= cfg_cap;
        cnt_r  <= '0;
        coll_r <= '0;
        scan_r <= '0;
      end else begin
        if (cmd.clr_step || cmd.grow_step || cmd.re_next) scan_r <= scan_r + 1'b1;
        if (cmd.grow_start) scan_r <= '0;
        if (cmd.place) cnt_r <= cnt_r + 1'b1;
        if (cmd.grow_finish) begin
          cap_r  <= cap_r + 1'b1;
          cnt_r  <= '0;
          scan_r <= '0;
        end
        if (cmd.count_coll && (coll_r != '1)) coll_r <= coll_r + 1'b1;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // probe and item payload
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      op_r      <= op_t'(in_tuser);
      ikey_r    <= in_key;
      ihash_r   <= in_hash;
      ival_r    <= in_val;
      ckey_r    <= in_key;
      chash_r   <= in_hash;
      cval_r    <= in_val;
      idx_r     <= (op_t'(in_tuser) == OP_NONE) ? '0 : (in_hash[SW-1:0] & mask);
      pert_r    <= in_hash;
      adv_r     <= '0;
      res_st_r  <= ST_NOTFOUND;
      res_val_r <= '0;
    end
    if (cmd.item_reprobe) begin
      ckey_r  <= ikey_r;
      chash_r <= ihash_r;
      cval_r  <= ival_r;
      idx_r   <= ihash_r[SW-1:0] & mask;
      pert_r  <= ihash_r;
      adv_r   <= '0;
    end
    if (cmd.re_load) begin
      ckey_r  <= scr_q[63:0];
      chash_r <= scr_q[127:64];
      cval_r  <= scr_q[191:128];
      idx_r   <= scr_q[64 +: SW] & mask;
      pert_r  <= scr_q[127:64];
      adv_r   <= '0;
    end
    if (cmd.probe_adv) begin
      pert_r <= pert_nxt;
      idx_r  <= idx_nxt;
      adv_r  <= adv_r + 1'b1;
    end
    if (cmd.grow_start) nent_r <= '0;
    else if (cmd.grow_step && used_q) nent_r <= nent_r + 1'b1;
    if (cmd.res_we) begin
      res_st_r  <= cmd.res_st;
      res_val_r <= cmd.res_val ? val_q : '0;
    end
    if (cmd.out_load) begin
      out_st_r   <= res_st_r;
      out_data_r <= OUT_W'({coll_r, CAPO_W'(cap_r), cnt_r, idx_r, res_val_r});
    end
  end

  // status to the controller
  always_comb begin
    sts.op        = op_r;
    sts.clr_done  = (scan_r[SW-1:0] == '1);
    sts.used      = used_q;
    sts.match     = used_q && (key_q == ckey_r) && (hash_q == chash_r);
    sts.lim       = (adv_r == (AW'(cap_size) + AW'(14)));
    sts.first     = (adv_r == '0);
    sts.need_grow = ({cnt_r, 2'b00} >= ((SW+3)'(3) << cap_r));
    sts.at_max    = (cap_r >= CAPW'(SW));
    sts.grow_last = (scan_r == (cap_size - 1'b1));
    sts.re_last   = ((scan_r + 1'b1) == nent_r);
    sts.re_empty  = (nent_r == '0);
    sts.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;

endmodule

// ===== hw/rtl/open_addressing_hash_table.sv =====
// Open-addressing hash table, perturbation probing, one transaction at a time.
// Each probe step reads a slot and then checks it; the result is loaded into the output register
// once that is free, and only then is the next input taken (operation 3 skips the probe).
// A growing insert scans every old slot and reinserts each stored entry, then probes
// the item again; a stalled result holds the input.
// Reset (rst_n low, synchronous) and every cfg write start a clearing pass over all 2^MAX_CAPACITY_LOG2 slots.
module open_addressing_hash_table #(
  parameter int MAX_CAPACITY_LOG2 = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [oaht_pkg::IN_W-1:0] in_tdata,   // key, hash, value
  input  logic [1:0]                in_tuser,   // operation
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // value_out, slot_index, entry_count, capacity_log2_now, collision_count
  output logic [((101 + 2*MAX_CAPACITY_LOG2 + 7) / 8) * 8 - 1:0] out_tdata,
  output logic [1:0]                out_tuser,  // status
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [3:0]                cfg_data    // initial_capacity_log2
);
  import oaht_pkg::*;

  localparam int OUT_W = ((101 + 2*MAX_CAPACITY_LOG2 + 7) / 8) * 8;

  cmd_t cmd;
  sts_t sts;

  oaht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  oaht_dp #(
    .MAX_CAPACITY_LOG2 (MAX_CAPACITY_LOG2),
    .OUT_W             (OUT_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== hw/rtl/oaht_checker.sv =====
// Port-level checker for the hash table, bound to the top level.
// Depends on oaht_pkg and open_addressing_hash_table_macros.svh.
`include "open_addressing_hash_table_macros.svh"

module oaht_checker #(
  parameter int MAX_CAPACITY_LOG2 = 10
) (
  input logic                                                   clk,
  input logic                                                   rst_n,
  input logic                                                   in_tvalid,
  input logic                                                   in_tready,
  input logic                                                   out_tvalid,
  input logic                                                   out_tready,
  input logic [((101 + 2*MAX_CAPACITY_LOG2 + 7) / 8) * 8 - 1:0] out_tdata,
  input logic [1:0]                                             out_tuser
);
  import oaht_pkg::*;

  localparam int SW   = MAX_CAPACITY_LOG2;
  localparam int CW   = SW + 1;
  localparam int CLSB = 64 + SW + CW;

  logic [CW-1:0]     cnt_f;
  logic [CAPO_W-1:0] cap_f;
  assign cnt_f = out_tdata[64 + SW +: CW];
  assign cap_f = out_tdata[CLSB +: CAPO_W];

  // stalled result holds
  `OAHT_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, $stable(out_tdata))
  // one transaction at a time: busy right after accept
  `OAHT_ASSERT_NXT(a_busy_after_in, in_tvalid && in_tready, !in_tready)
  // refusal only at maximum capacity
  `OAHT_ASSERT_IMP(a_full_at_max, out_tvalid && (out_tuser == ST_FULL),
                   cap_f == CAPO_W'(SW))
  // entry count never exceeds the bucket count
  `OAHT_ASSERT_IMP(a_cnt_le_cap, out_tvalid,
                   {1'b0, cnt_f} <= ((CW+1)'(1) << cap_f))

endmodule

bind open_addressing_hash_table oaht_checker #(
  .MAX_CAPACITY_LOG2 (MAX_CAPACITY_LOG2)
) u_oaht_checker (.*);

// ===== test/tb_open_addressing_hash_table.sv =====
// Self-checking testbench for the open-addressing hash table over its stream ports.
// Depends on oaht_pkg and open_addressing_hash_table; a class predicts each result.
`timescale 1ns / 100ps

module tb_open_addressing_hash_table;
  import oaht_pkg::*;

  localparam int  MAXLOG    = 10;
  localparam int  OUT_W     = ((101 + 2*MAXLOG + 7) / 8) * 8;
  localparam int  LIMIT     = 2000000;
  localparam int  DRAIN     = 40;
  localparam int  POOL      = 48;

  // one expected result transaction
  typedef struct {
    st_t          status;
    logic [63:0]  value_out;
    logic [9:0]   slot_index;
    logic [10:0]  entry_count;
    logic [3:0]   cap_log2;
    logic [31:0]  collisions;
  } hash_result_t;

  // Table shadow: predicts each result and checks the block's output in order
  class hash_table_shadow;
    logic [63:0] keys [1024];
    logic [63:0] hashes [1024];
    logic [63:0] values [1024];
    bit          used [1024];
    int unsigned count;
    int unsigned cap_log2;
    int unsigned collisions;
    int unsigned errors;
    hash_result_t pending_q[$];

    function void restart(logic [3:0] init_log2);
      for (int i = 0; i < 1024; i++) begin
        keys[i] = '0; hashes[i] = '0; values[i] = '0; used[i] = 0;
      end
      count      = 0;
      collisions = 0;
      cap_log2   = (init_log2 > MAXLOG) ? MAXLOG : init_log2;
    endfunction

    function void bump_collisions();
      if (collisions != 32'hFFFF_FFFF) collisions++;
    endfunction

    // walks the probe chain; returns 1 on a match, slot = match/empty/last slot
    function bit find_slot(logic [63:0] key, logic [63:0] hash, output int slot);
      logic [63:0] mask;
      logic [63:0] idx;
      logic [63:0] perturb;
      int          steps;
      mask    = (64'd1 << cap_log2) - 64'd1;
      idx     = hash & mask;
      perturb = hash;
      steps   = (1 << cap_log2) + 14;
      slot    = int'(idx);
      if (!used[idx]) return 0;
      if (keys[idx] == key && hashes[idx] == hash) return 1;
      bump_collisions();
      for (int s = 0; s < steps; s++) begin
        perturb = perturb >> 5;
        idx     = (idx * 64'd5 + perturb + 64'd1) & mask;
        slot    = int'(idx);
        if (!used[idx]) return 0;
        if (keys[idx] == key && hashes[idx] == hash) return 1;
      end
      return 0;
    endfunction

    function void put(int slot, logic [63:0] key, logic [63:0] hash, logic [63:0] val);
      keys[slot] = key; hashes[slot] = hash; values[slot] = val; used[slot] = 1;
      count++;
    endfunction

    // doubles capacity, reinserting old entries in slot order
    function void grow();
      logic [63:0] ok[$];
      logic [63:0] oh[$];
      logic [63:0] ov[$];
      int          slot;
      bit          hit;
      for (int i = 0; i < (1 << cap_log2); i++)
        if (used[i]) begin
          ok.push_back(keys[i]); oh.push_back(hashes[i]); ov.push_back(values[i]);
        end
      for (int i = 0; i < 1024; i++) begin
        keys[i] = '0; hashes[i] = '0; values[i] = '0; used[i] = 0;
      end
      count = 0;
      cap_log2++;
      foreach (ok[i]) begin
        hit = find_slot(ok[i], oh[i], slot);
        put(slot, ok[i], oh[i], ov[i]);
      end
    endfunction

    function void note_item(op_t op, logic [63:0] key, logic [63:0] hash,
                            logic [63:0] val);
      hash_result_t r;
      int           slot;
      bit           hit;
      bit           need;
      r.status    = ST_NOTFOUND;
      r.value_out = '0;
      slot        = 0;
      case (op)
        OP_INSERT: begin
          hit = find_slot(key, hash, slot);
          if (hit) r.status = ST_FOUND;
          else begin
            need = (4 * count) >= (3 * (1 << cap_log2));
            if (need && cap_log2 >= MAXLOG) r.status = ST_FULL;
            else begin
              if (need) begin
                grow();
                hit = find_slot(key, hash, slot);
              end
              put(slot, key, hash, val);
              r.status = ST_OK;
            end
          end
        end
        OP_LOOKUP: begin
          hit = find_slot(key, hash, slot);
          if (hit) begin
            r.status    = ST_FOUND;
            r.value_out = values[slot];
          end
        end
        OP_UPDATE: begin
          hit = find_slot(key, hash, slot);
          if (hit) begin
            values[slot] = val;
            r.status     = ST_OK;
          end
        end
        default: ;
      endcase
      r.slot_index  = slot[9:0];
      r.entry_count = count[10:0];
      r.cap_log2    = cap_log2[3:0];
      r.collisions  = collisions;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [OUT_W-1:0] d);
      hash_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d data %h", $time, st, d);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (st != e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, st); errors++;
      end
      if (d[63:0] != e.value_out) begin
        $display("%0t: value_out exp %h got %h", $time, e.value_out, d[63:0]); errors++;
      end
      if (d[73:64] != e.slot_index) begin
        $display("%0t: slot_index exp %0d got %0d", $time, e.slot_index, d[73:64]);
        errors++;
      end
      if (d[84:74] != e.entry_count) begin
        $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count, d[84:74]);
        errors++;
      end
      if (d[88:85] != e.cap_log2) begin
        $display("%0t: capacity_log2 exp %0d got %0d", $time, e.cap_log2, d[88:85]);
        errors++;
      end
      if (d[120:89] != e.collisions) begin
        $display("%0t: collision_count exp %0d got %0d", $time, e.collisions, d[120:89]);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;   // key, hash, value
  logic [1:0]           in_tuser = '0;   // operation
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // value_out, slot_index, entry_count, capacity_log2_now, collision_count
  logic [OUT_W-1:0]     out_tdata;
  logic [1:0]           out_tuser;       // status
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [3:0]           cfg_data = '0;   // initial_capacity_log2

  hash_table_shadow     shadow = new();
  int unsigned          cycle_count = 0;
  int unsigned          hold_off = 0;
  int unsigned          burst_left = 1;
  logic [63:0]          key_pool [POOL];
  logic [63:0]          hash_pool [POOL];

  open_addressing_hash_table #(.MAX_CAPACITY_LOG2(MAXLOG)) i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("FAIL open_addressing_hash_table");
      $finish;
    end
  end

  // monitors: accepted input and result transactions
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      shadow.note_item(op_t'(in_tuser), in_tdata[63:0], in_tdata[127:64],
                       in_tdata[191:128]);
    if (rst_n && out_tvalid && out_tready)
      shadow.check_result(out_tuser, out_tdata);
  end

  // receiver: stall pattern chosen by cycle_count bits 9:8; long hold-off on request
  always @(posedge clk) begin
    if (hold_off != 0) begin
      hold_off   <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      case (cycle_count[9:8])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= ($urandom_range(0, 9) > 2);
        2'd2:    out_tready <= (cycle_count % 3 != 0);
        default: out_tready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // one input transaction, then a random gap at the end of a burst
  task automatic send_item(op_t op, logic [63:0] key, logic [63:0] hash,
                           logic [63:0] val);
    in_tuser  <= op;
    in_tdata  <= {val, hash, key};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
  endtask

  // wait for all results, then write the capacity register
  task automatic write_cfg(logic [3:0] v);
    if (in_tvalid) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    while (shadow.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow.restart(v);
  endtask

  task automatic fill_pool();
    for (int i = 0; i < POOL; i++) begin
      key_pool[i]  = {$urandom, $urandom};
      hash_pool[i] = {$urandom, $urandom};
    end
  endtask

  // random traffic over a small key pool so hits, updates and collisions occur
  task automatic random_items(int n);
    int          p;
    int          r;
    op_t         op;
    logic [63:0] key;
    logic [63:0] hash;
    for (int i = 0; i < n; i++) begin
      p    = $urandom_range(0, POOL - 1);
      key  = key_pool[p];
      hash = hash_pool[p];
      r    = $urandom_range(0, 99);
      if (r < 10) hash = hash_pool[$urandom_range(0, POOL - 1)];
      else if (r < 15) begin
        key  = {$urandom, $urandom};
        hash = {$urandom, $urandom};
      end
      r  = $urandom_range(0, 99);
      op = (r < 45) ? OP_INSERT : (r < 75) ? OP_LOOKUP : (r < 95) ? OP_UPDATE : OP_NONE;
      send_item(op, key, hash, {$urandom, $urandom});
    end
  endtask

  initial begin
    logic [63:0] big_keys[$];
    logic [63:0] big_hashes[$];
    int          p;

    // reset
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    shadow.restart(4'd4);

    // directed: extremes, every operation, colliding home slots, growth
    send_item(OP_INSERT, 64'd0, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(OP_INSERT, '1, '1, 64'h8000_0000_0000_0000);
    send_item(OP_INSERT, 64'd5, 64'd16, '1);
    send_item(OP_INSERT, 64'd0, 64'd0, 64'd7);
    send_item(OP_LOOKUP, 64'd0, 64'd0, 64'd0);
    send_item(OP_LOOKUP, 64'd5, 64'd16, 64'd0);
    send_item(OP_LOOKUP, 64'd0, 64'd16, 64'd0);
    send_item(OP_UPDATE, 64'd5, 64'd16, 64'd123);
    send_item(OP_LOOKUP, 64'd5, 64'd16, 64'd0);
    send_item(OP_UPDATE, 64'd9, 64'd9, 64'd1);
    send_item(OP_NONE, '1, '1, '1);
    send_item(OP_LOOKUP, '1, '1, 64'd0);
    for (int i = 1; i <= 11; i++)
      send_item(OP_INSERT, 64'd100 + i, 64'(i) << 4, 64'(i));
    send_item(OP_LOOKUP, 64'd105, 64'd80, 64'd0);

    // capacity 1: full-table probes, growth from the smallest size
    write_cfg(4'd0);
    fill_pool();
    random_items(300);

    // capacity 4, with a long receiver hold-off that outlasts the clearing pass
    write_cfg(4'd2);
    fill_pool();
    hold_off = 1500;
    random_items(300);

    // clamped to maximum capacity: fill until inserts are refused
    write_cfg(4'd15);
    for (int i = 0; i < 775; i++) begin
      big_keys.push_back({$urandom, $urandom});
      big_hashes.push_back({$urandom, $urandom});
      send_item(OP_INSERT, big_keys[i], big_hashes[i], {$urandom, $urandom});
    end
    for (int i = 0; i < 120; i++) begin
      p = $urandom_range(0, 774);
      send_item(($urandom_range(0, 1) == 1) ? OP_LOOKUP : OP_UPDATE,
                big_keys[p], big_hashes[p], {$urandom, $urandom});
    end

    // explicit maximum, then a mid size
    write_cfg(4'd10);
    fill_pool();
    random_items(100);
    write_cfg(4'd5);
    fill_pool();
    random_items(250);

    // drain
    in_tvalid <= 1'b0;
    while (shadow.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (shadow.errors == 0)
      $display("PASS open_addressing_hash_table");
    else
      $display("FAIL open_addressing_hash_table");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_ctrl.sv
hw/rtl/oaht_dp.sv
hw/rtl/open_addressing_hash_table.sv
hw/rtl/oaht_checker.sv
test/tb_open_addressing_hash_table.sv
